/* src/ilf_pkg.sv */
// Shared types and constants of the iterative learning feed-forward block.
// No dependencies; imported by the interfaces, the top level and the checker.
`default_nettype none

package ilf_pkg;

  // Storage geometry
  localparam int MAX_STEPS = 1024;
  localparam int ADDR_W    = $clog2(MAX_STEPS);

  // Field widths
  localparam int LEN_W      = 11;
  localparam int GAIN_W     = 16;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 16;
  localparam int IDX_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_LOAD_ACK   = 3'd0,
    KIND_COMMAND    = 3'd1,
    KIND_TRIAL_DONE = 3'd2,
    KIND_READ_DATA  = 3'd3,
    KIND_IDLE_TICK  = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRAJ_LEN = 1'd0,
    CFG_GAIN     = 1'd1
  } cfg_reg_t;

  // Word of the trajectory memory
  typedef struct packed {
    logic signed [DATA_W-1:0] reference;
    logic signed [DATA_W-1:0] command;
  } traj_word_t;

  // Word of the tracking memory
  typedef struct packed {
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] error;
  } track_word_t;

  // One response
  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] command_out;
    logic [CNT_W-1:0]         trial_count;
    logic signed [DATA_W-1:0] read_reference;
    logic signed [DATA_W-1:0] read_command;
    logic signed [DATA_W-1:0] read_measured;
    logic signed [DATA_W-1:0] read_error;
  } rsp_t;

endpackage

`default_nettype wire

/* src/ilf_req_if.sv */
// Request channel of the learning block: valid/ready plus one request's fields.
// Depends on ilf_pkg.
`default_nettype none

interface ilf_req_if import ilf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] ref_value;
  logic signed [DATA_W-1:0] measured_position;

  modport source (output valid, action, entry_index, ref_value, measured_position,
                  input ready);
  modport sink   (input valid, action, entry_index, ref_value, measured_position,
                  output ready);
endinterface

`default_nettype wire

/* src/ilf_rsp_if.sv */
// Response channel of the learning block: valid/ready plus one response's fields.
// Depends on ilf_pkg.
`default_nettype none

interface ilf_rsp_if import ilf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               kind;
  logic signed [DATA_W-1:0] command_out;
  logic [CNT_W-1:0]         trial_count;
  logic signed [DATA_W-1:0] read_reference;
  logic signed [DATA_W-1:0] read_command;
  logic signed [DATA_W-1:0] read_measured;
  logic signed [DATA_W-1:0] read_error;

  modport source (output valid, kind, command_out, trial_count, read_reference,
                  read_command, read_measured, read_error, input ready);
  modport sink   (input valid, kind, command_out, trial_count, read_reference,
                  read_command, read_measured, read_error, output ready);
endinterface

`default_nettype wire

/* src/ilf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ilf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/iterative_learning_feedforward.sv */
// Top level of the P-type iterative learning feed-forward controller.
// Depends on ilf_pkg, ilf_req_if, ilf_rsp_if and ilf_ram.
`default_nettype none

// After reset the block runs a clearing pass over all MAX_STEPS (1024)
// entries of the tracking memory and takes no request meanwhile;
// configuration writes are taken at any time. Per request: start gives no
// response, load and idle tick go straight to the response, command tick
// and read do one memory read, then the response. The tick that ends a
// trial walks every active entry, min(trajectory_length, MAX_STEPS) of
// them, through a shared read / subtract / multiply / write-back sequence.
// Each request is finished before the next is taken; a response waits in the
// output register until taken while the next request is already accepted.
module iterative_learning_feedforward import ilf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  ilf_req_if.sink                    req,
  ilf_rsp_if.source                  rsp
);

  localparam int PROD_W = GAIN_W + DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_SH = 12;
  localparam int CORR_W = SUM_W - RND_SH;
  localparam int EXT_W  = CORR_W - DATA_W + 1;
  localparam logic [RND_SH-1:0] RND_HALF = RND_SH'(1) << (RND_SH - 1);
  localparam logic [DATA_W-1:0] SAT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_TICK_RD = 9'b000000100,
    S_READ    = 9'b000001000,
    S_UPD_RD  = 9'b000010000,
    S_UPD_ERR = 9'b000100000,
    S_UPD_MUL = 9'b001000000,
    S_UPD_WR  = 9'b010000000,
    S_PUT     = 9'b100000000
  } state_t;

  // Control registers
  state_t             state, state_next;
  logic [LEN_W-1:0]   trajectory_length;
  logic [GAIN_W-1:0]  learning_gain;
  logic [LEN_W-1:0]   step_pointer, step_pointer_next;
  logic               trial_running, trial_running_next;
  logic [CNT_W-1:0]   trials_done, trials_done_next;
  logic [ADDR_W-1:0]  clr_addr, clr_addr_next;
  logic               rsp_valid;

  // Payload registers
  logic [ADDR_W-1:0]        upd_addr, upd_addr_next;
  logic [ADDR_W-1:0]        acc_addr, acc_addr_next;
  logic signed [DATA_W-1:0] meas_hold, meas_hold_next;
  logic signed [DATA_W-1:0] err, err_next;
  logic signed [PROD_W-1:0] prod, prod_next;
  rsp_t                     res, res_next;
  rsp_t                     rsp_data;

  // Memory ports
  logic              traj_we, traj_re, track_we, track_re;
  logic [ADDR_W-1:0] traj_waddr, traj_raddr, track_waddr, track_raddr;
  traj_word_t        traj_wdata, traj_rdata;
  track_word_t       track_wdata, track_rdata;

  // Datapath helpers
  logic [LEN_W-1:0]         active_len;
  logic                     idx_ok;
  logic                     accept;
  logic                     last_entry;
  logic signed [DATA_W:0]   diff;
  logic signed [SUM_W-1:0]  upd_sum;
  logic signed [CORR_W-1:0] upd_val;
  logic signed [DATA_W-1:0] new_cmd;

  ilf_ram #(.WIDTH($bits(traj_word_t)), .DEPTH(MAX_STEPS)) u_traj_ram (
    .clk   (clk),
    .we    (traj_we),
    .waddr (traj_waddr),
    .wdata (traj_wdata),
    .re    (traj_re),
    .raddr (traj_raddr),
    .rdata (traj_rdata)
  );

  ilf_ram #(.WIDTH($bits(track_word_t)), .DEPTH(MAX_STEPS)) u_track_ram (
    .clk   (clk),
    .we    (track_we),
    .waddr (track_waddr),
    .wdata (track_wdata),
    .re    (track_re),
    .raddr (track_raddr),
    .rdata (track_rdata)
  );

  // Length clipped to the memory depth, index range check
  assign active_len = (32'(trajectory_length) > 32'(MAX_STEPS)) ? LEN_W'(MAX_STEPS)
                                                               : trajectory_length;
  assign idx_ok     = 32'(req.entry_index) < 32'(MAX_STEPS);
  assign accept     = req.valid && req.ready;
  assign last_entry = (LEN_W'(upd_addr) + LEN_W'(1)) == active_len;

  // Error: saturated reference minus measured
  assign diff = (DATA_W+1)'($signed(traj_rdata.reference))
              - (DATA_W+1)'($signed(track_rdata.measured));

  // Command update: cmd + floor((gain*err + half) / 2^12), saturated
  assign upd_sum = $signed({CORR_W'($signed(traj_rdata.command)), RND_HALF})
                 + SUM_W'(prod);
  assign upd_val = upd_sum[SUM_W-1:RND_SH];

  always_comb begin
    if (upd_val[CORR_W-1:DATA_W-1] != {EXT_W{upd_val[CORR_W-1]}}) begin
      new_cmd = upd_val[CORR_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      new_cmd = upd_val[DATA_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next         = state;
    step_pointer_next  = step_pointer;
    trial_running_next = trial_running;
    trials_done_next   = trials_done;
    clr_addr_next      = clr_addr;
    upd_addr_next      = upd_addr;
    acc_addr_next      = acc_addr;
    meas_hold_next     = meas_hold;
    err_next           = err;
    prod_next          = prod;
    res_next           = res;
    traj_we            = 1'b0;
    traj_waddr         = ADDR_W'(req.entry_index);
    traj_wdata         = '{reference: req.ref_value, command: req.ref_value};
    traj_re            = 1'b0;
    traj_raddr         = ADDR_W'(req.entry_index);
    track_we           = 1'b0;
    track_waddr        = ADDR_W'(req.entry_index);
    track_wdata        = '0;
    track_re           = 1'b0;
    track_raddr        = ADDR_W'(req.entry_index);

    case (state)
      // Zero the tracking memory after reset
      S_CLEAR: begin
        track_we      = 1'b1;
        track_waddr   = clr_addr;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(MAX_STEPS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (req.action)
            ACT_LOAD: begin
              traj_we          = idx_ok;
              track_we         = idx_ok;
              trials_done_next = '0;
              res_next         = '0;
              res_next.kind    = KIND_LOAD_ACK;
              state_next       = S_PUT;
            end
            ACT_START: begin
              if (!trial_running) begin
                step_pointer_next  = '0;
                trial_running_next = 1'b1;
              end
            end
            ACT_TICK: begin
              res_next             = '0;
              res_next.trial_count = trials_done;
              if (!trial_running) begin
                res_next.kind = KIND_IDLE_TICK;
                state_next    = S_PUT;
              end else if (step_pointer < active_len) begin
                traj_re        = 1'b1;
                traj_raddr     = ADDR_W'(step_pointer);
                track_re       = 1'b1;
                track_raddr    = ADDR_W'(step_pointer);
                acc_addr_next  = ADDR_W'(step_pointer);
                meas_hold_next = req.measured_position;
                state_next     = S_TICK_RD;
              end else begin
                trial_running_next = 1'b0;
                step_pointer_next  = '0;
                upd_addr_next      = '0;
                if (active_len == '0) begin
                  trials_done_next     = trials_done + CNT_W'(1);
                  res_next.kind        = KIND_TRIAL_DONE;
                  res_next.trial_count = trials_done + CNT_W'(1);
                  state_next           = S_PUT;
                end else begin
                  state_next = S_UPD_RD;
                end
              end
            end
            ACT_READ: begin
              res_next             = '0;
              res_next.kind        = KIND_READ_DATA;
              res_next.trial_count = trials_done;
              if (idx_ok) begin
                traj_re       = 1'b1;
                track_re      = 1'b1;
                acc_addr_next = ADDR_W'(req.entry_index);
                state_next    = S_READ;
              end else begin
                state_next = S_PUT;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // Record the measurement, keep the stored error, return the command
      S_TICK_RD: begin
        track_we             = 1'b1;
        track_waddr          = acc_addr;
        track_wdata          = '{measured: meas_hold, error: track_rdata.error};
        res_next.kind        = KIND_COMMAND;
        res_next.command_out = traj_rdata.command;
        step_pointer_next    = step_pointer + LEN_W'(1);
        state_next           = S_PUT;
      end

      S_READ: begin
        res_next.read_reference = traj_rdata.reference;
        res_next.read_command   = traj_rdata.command;
        res_next.read_measured  = track_rdata.measured;
        res_next.read_error     = track_rdata.error;
        state_next              = S_PUT;
      end

      // Learning pass, one entry at a time through read, error, multiply and write-back
      S_UPD_RD: begin
        traj_re     = 1'b1;
        traj_raddr  = upd_addr;
        track_re    = 1'b1;
        track_raddr = upd_addr;
        state_next  = S_UPD_ERR;
      end

      S_UPD_ERR: begin
        if (diff[DATA_W] != diff[DATA_W-1]) begin
          err_next = diff[DATA_W] ? SAT_MIN : SAT_MAX;
        end else begin
          err_next = diff[DATA_W-1:0];
        end
        state_next = S_UPD_MUL;
      end

      S_UPD_MUL: begin
        prod_next  = PROD_W'($signed(learning_gain)) * PROD_W'(err);
        state_next = S_UPD_WR;
      end

      S_UPD_WR: begin
        traj_we     = 1'b1;
        traj_waddr  = upd_addr;
        traj_wdata  = '{reference: traj_rdata.reference, command: new_cmd};
        track_we    = 1'b1;
        track_waddr = upd_addr;
        track_wdata = '{measured: track_rdata.measured, error: err};
        if (last_entry) begin
          trials_done_next     = trials_done + CNT_W'(1);
          res_next.kind        = KIND_TRIAL_DONE;
          res_next.trial_count = trials_done + CNT_W'(1);
          state_next           = S_PUT;
        end else begin
          upd_addr_next = upd_addr + ADDR_W'(1);
          state_next    = S_UPD_RD;
        end
      end

      // Hand the response to the output register once it is free
      S_PUT: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      trajectory_length <= '0;
      learning_gain     <= '0;
      step_pointer      <= '0;
      trial_running     <= 1'b0;
      trials_done       <= '0;
      clr_addr          <= '0;
      rsp_valid         <= 1'b0;
    end else begin
      state         <= state_next;
      step_pointer  <= step_pointer_next;
      trial_running <= trial_running_next;
      trials_done   <= trials_done_next;
      clr_addr      <= clr_addr_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRAJ_LEN: trajectory_length <= cfg_data[LEN_W-1:0];
          CFG_GAIN:     learning_gain     <= cfg_data[GAIN_W-1:0];
          default:      trajectory_length <= trajectory_length;
        endcase
      end
      if (state == S_PUT && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    upd_addr  <= upd_addr_next;
    acc_addr  <= acc_addr_next;
    meas_hold <= meas_hold_next;
    err       <= err_next;
    prod      <= prod_next;
    res       <= res_next;
    if (state == S_PUT && (!rsp_valid || rsp.ready)) begin
      rsp_data <= res;
    end
  end

  // Ports
  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.kind           = rsp_data.kind;
  assign rsp.command_out    = rsp_data.command_out;
  assign rsp.trial_count    = rsp_data.trial_count;
  assign rsp.read_reference = rsp_data.read_reference;
  assign rsp.read_command   = rsp_data.read_command;
  assign rsp.read_measured  = rsp_data.read_measured;
  assign rsp.read_error     = rsp_data.read_error;

endmodule

`default_nettype wire

/* src/ilf_checker.sv */
// Port-level checks of the learning block and their bind to the top level.
// Depends on ilf_pkg and iterative_learning_feedforward.
`default_nettype none

module ilf_checker import ilf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [2:0]        rsp_kind,
  input wire logic [DATA_W-1:0] rsp_command_out,
  input wire logic [CNT_W-1:0]  rsp_trial_count
);

  // Clearing pass keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken during clearing pass");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
                                && $stable(rsp_command_out))
    else $error("stalled response changed");

  // A load restarts trial counting
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_LOAD_ACK |-> rsp_trial_count == '0)
    else $error("load ack with non-zero trial count");

  // Only command responses carry a command
  a_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind != KIND_COMMAND |-> rsp_command_out == '0)
    else $error("command value on non-command response");

endmodule

bind iterative_learning_feedforward ilf_checker u_ilf_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_kind        (rsp.kind),
  .rsp_command_out (rsp.command_out),
  .rsp_trial_count (rsp.trial_count)
);

`default_nettype wire
